// ----- hdl/whbs_pkg.sv -----
// ============================================================================
// whbs_pkg: shared types, codes and saturating helpers
// Command and target codes, the memory entry layouts, the request structs of
// the shared multiplier and divider, and the saturating add and subtract.
// ============================================================================
package whbs_pkg;

  localparam int BINS_DEF   = 256;
  localparam int NUM_TOTALS = 3;

  localparam logic [2:0] CMD_ESCAPE  = 3'd0;
  localparam logic [2:0] CMD_RC      = 3'd1;
  localparam logic [2:0] CMD_AC      = 3'd2;
  localparam logic [2:0] CMD_ACCUM   = 3'd3;
  localparam logic [2:0] CMD_ZBATCH  = 3'd4;
  localparam logic [2:0] CMD_ZALL    = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  localparam logic [2:0] TGT_RC_BIN  = 3'd3;
  localparam logic [2:0] TGT_AC_BIN  = 3'd4;

  localparam logic CFG_BIN_SCALE = 1'b0;
  localparam logic CFG_RECIP     = 1'b1;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [47:0] rc_sum;
    logic signed [47:0] ac_sum;
  } bin_sum_t;

  typedef struct packed {
    logic signed [63:0] rc_mean;
    logic signed [63:0] rc_m2;
    logic signed [63:0] ac_mean;
    logic signed [63:0] ac_m2;
  } bin_stat_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic               sh16;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic [15:0]        divisor;
  } div_req_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [47:0] sum_add48(input logic signed [47:0] s,
                                                   input logic signed [31:0] w);
    logic signed [48:0] r;
    logic signed [47:0] o;
    r = {s[47], s} + {{17{w[31]}}, w};
    if (r[48] != r[47]) begin
      o = r[48] ? S48_MIN : S48_MAX;
    end else begin
      o = r[47:0];
    end
    return o;
  endfunction

endpackage

// ----- hdl/whbs_mulacc.sv -----
// ============================================================================
// whbs_mulacc: shared multiply-and-scale unit
// Signed 64x64 product built from four 32x32 partial products, then a floor
// shift right by 16 or 32 and saturation to the signed 64-bit range.
// ============================================================================
module whbs_mulacc
  import whbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_MUL  = 5'b00010,
    M_ADD  = 5'b00100,
    M_FIN  = 5'b01000,
    M_SAT  = 5'b10000
  } mul_state_e;

  mul_state_e   state_q;
  logic         neg_q, sh16_q;
  logic [63:0]  ua_q, ub_q, pp_q;
  logic [127:0] acc_q, q_q;
  logic [1:0]   step_q;

  logic [31:0]  a_part, b_part;
  logic [127:0] pp_ext, shifted;
  logic         rem;

  assign a_part  = step_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign b_part  = step_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign shifted = sh16_q ? (acc_q >> 16) : (acc_q >> 32);
  assign rem     = sh16_q ? (|acc_q[15:0]) : (|acc_q[31:0]);

  always_comb begin
    unique case ({1'b0, step_q[1]} + {1'b0, step_q[0]})
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
      default: pp_ext = {pp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_o  <= 1'b0;
      step_q  <= 2'd0;
    end else begin
      done_o <= (state_q == M_SAT);
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            neg_q   <= req_i.a[63] ^ req_i.b[63];
            sh16_q  <= req_i.sh16;
            ua_q    <= req_i.a[63] ? (64'd0 - req_i.a) : req_i.a;
            ub_q    <= req_i.b[63] ? (64'd0 - req_i.b) : req_i.b;
            acc_q   <= '0;
            step_q  <= 2'd0;
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          pp_q    <= a_part * b_part;
          state_q <= M_ADD;
        end
        M_ADD: begin
          acc_q  <= acc_q + pp_ext;
          step_q <= step_q + 2'd1;
          state_q <= (step_q == 2'd3) ? M_FIN : M_MUL;
        end
        M_FIN: begin
          // Negative results round away from zero in magnitude, i.e. floor.
          q_q     <= shifted + {127'd0, neg_q & rem};
          state_q <= M_SAT;
        end
        M_SAT: begin
          if (|q_q[127:63]) begin
            res_o <= neg_q ? S64_MIN : S64_MAX;
          end else begin
            res_o <= neg_q ? (64'd0 - q_q[63:0]) : q_q[63:0];
          end
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/whbs_divider.sv -----
// ============================================================================
// whbs_divider: radix-2 restoring divider
// Signed 64-bit dividend over an unsigned nonzero 16-bit divisor, one quotient
// bit per cycle, truncating toward zero.
// ============================================================================
module whbs_divider
  import whbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } div_state_e;

  div_state_e  state_q;
  logic        neg_q;
  logic [63:0] num_q;
  logic [15:0] rem_q, den_q;
  logic [5:0]  cnt_q;

  logic [16:0] trial, diff;
  logic        qbit;

  assign trial = {rem_q, num_q[63]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_o <= (state_q == D_FIN);
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            neg_q   <= req_i.dividend[63];
            num_q   <= req_i.dividend[63] ? (64'd0 - req_i.dividend) : req_i.dividend;
            den_q   <= req_i.divisor;
            rem_q   <= '0;
            cnt_q   <= 6'd63;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q   <= qbit ? diff[15:0] : trial[15:0];
          num_q   <= {num_q[62:0], qbit};
          cnt_q   <= cnt_q - 6'd1;
          state_q <= (cnt_q == 6'd0) ? D_FIN : D_RUN;
        end
        D_FIN: begin
          quot_o  <= neg_q ? (64'd0 - num_q) : num_q;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/whbs_binmem.sv -----
// ============================================================================
// whbs_binmem: histogram bin storage
// One entry per bin: the batch sums of both histograms and the running
// mean and m2 of both. Single address, registered read data.
// ============================================================================
module whbs_binmem
  import whbs_pkg::*;
#(
  parameter int BINS = BINS_DEF,
  parameter int BW   = 8
) (
  input  logic          clk_i,
  input  logic [BW-1:0] addr_i,
  input  logic          sum_we_i,
  input  bin_sum_t      sum_wdata_i,
  input  logic          stat_we_i,
  input  bin_stat_t     stat_wdata_i,
  output bin_sum_t      sum_rdata_o,
  output bin_stat_t     stat_rdata_o
);

  bin_sum_t  sum_mem  [BINS];
  bin_stat_t stat_mem [BINS];

  always_ff @(posedge clk_i) begin
    if (sum_we_i) begin
      sum_mem[addr_i] <= sum_wdata_i;
    end
    if (stat_we_i) begin
      stat_mem[addr_i] <= stat_wdata_i;
    end
    sum_rdata_o  <= sum_mem[addr_i];
    stat_rdata_o <= stat_mem[addr_i];
  end

endmodule

// ----- hdl/weighted_histogram_batch_statistics_unit.sv -----
// ============================================================================
// weighted_histogram_batch_statistics_unit: weighted tally with statistics
// Scores signed weights into three batch totals and two histograms and
// folds each batch into running Welford mean and m2 on command.
// ============================================================================
//
//  channel   handshake                 payload
//  --------  ------------------------  ----------------------------------------
//  command   start / busy              command, weight, position, batch_number,
//                                      read_target, read_bin
//  result    valid_o (one-cycle beat)  mean_value, sum_sq_dev, batch_sum, status
//  config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A beat is taken when start is high and busy is low. Escape scores update
// their total directly; collision scores make one pass through the shared
// multiplier for the bin index (negative positions take bin 0), then a
// read-modify-write of the bin; reads fetch the entry, then present it.
// Accumulate runs one Welford update per total and two per bin, each bounded
// by the bit-serial divider and the four-pass multiplier. Zero commands sweep
// the bin memory. After reset the block sweeps the bin memory with busy high.
// The result beat cannot be stalled; it is shown for exactly one cycle.
//
module weighted_histogram_batch_statistics_unit
  import whbs_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] weight_i,
  input  logic signed [31:0] position_i,
  input  logic [15:0]        batch_number_i,
  input  logic [2:0]         read_target_i,
  input  logic [7:0]         read_bin_i,
  output logic               valid_o,
  output logic signed [63:0] mean_value_o,
  output logic signed [63:0] sum_sq_dev_o,
  output logic signed [47:0] batch_sum_o,
  output logic               status_o
);

  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [BW-1:0] LAST_BIN = BW'(BINS - 1);

  // One-hot sequencer states.
  typedef enum logic [13:0] {
    ST_CLEAR   = 14'b00000000000001,
    ST_IDLE    = 14'b00000000000010,
    ST_SC_BIN  = 14'b00000000000100,
    ST_SC_RD   = 14'b00000000001000,
    ST_SC_WR   = 14'b00000000010000,
    ST_RD_RD   = 14'b00000000100000,
    ST_RD_OUT  = 14'b00000001000000,
    ST_AC_LOAD = 14'b00000010000000,
    ST_AC_BRD  = 14'b00000100000000,
    ST_AC_V    = 14'b00001000000000,
    ST_AC_SUB  = 14'b00010000000000,
    ST_AC_DIV  = 14'b00100000000000,
    ST_AC_DNEW = 14'b01000000000000,
    ST_AC_MUL  = 14'b10000000000000
  } seq_state_e;

  seq_state_e state_q;

  logic [31:0] bin_scale_q, recip_q;

  // Item context latched when a beat is taken.
  logic [2:0]         cmd_q;
  logic signed [31:0] w_q;
  logic [15:0]        n_q;
  logic [2:0]         t_idx_q;
  logic               oob_q;
  logic               clr_all_q;
  logic               half_q;
  logic [BW-1:0]      addr_q;

  // The three totals and their running statistics.
  logic signed [47:0] tot_sum_q  [NUM_TOTALS];
  logic signed [63:0] tot_mean_q [NUM_TOTALS];
  logic signed [63:0] tot_m2_q   [NUM_TOTALS];

  // Welford working registers.
  logic signed [63:0] v_q, mean_q, m2_q, dold_q, nm_q;
  bin_sum_t           ent_sum_q;
  bin_stat_t          ent_stat_q;

  mul_req_t           mul_req;
  div_req_t           div_req;
  logic               mul_done, div_done;
  logic signed [63:0] mul_res, div_quot;

  logic               sum_we, stat_we;
  bin_sum_t           sum_wdata, sum_rdata;
  bin_stat_t          stat_wdata, stat_rdata;

  logic               accept, is_total;
  logic [1:0]         tix;
  logic signed [63:0] m2_new;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign tix      = t_idx_q[1:0];
  assign is_total = (t_idx_q < 3'(NUM_TOTALS));
  assign m2_new   = sat_add64(m2_q, mul_res);

  whbs_mulacc u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  whbs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  whbs_binmem #(
    .BINS (BINS),
    .BW   (BW)
  ) u_mem (
    .clk_i        (clk_i),
    .addr_i       (addr_q),
    .sum_we_i     (sum_we),
    .sum_wdata_i  (sum_wdata),
    .stat_we_i    (stat_we),
    .stat_wdata_i (stat_wdata),
    .sum_rdata_o  (sum_rdata),
    .stat_rdata_o (stat_rdata)
  );

  // The shared multiplier serves three jobs: the bin index of a collision
  // (shift 32), the scaled batch total (shift 16) and the m2 product.
  always_comb begin
    mul_req = '0;
    if (state_q == ST_IDLE && accept && !position_i[31] &&
        (command_i == CMD_RC || command_i == CMD_AC)) begin
      mul_req.start = 1'b1;
      mul_req.a     = {{32{position_i[31]}}, position_i};
      mul_req.b     = {32'd0, bin_scale_q};
    end else if (state_q == ST_AC_LOAD && is_total) begin
      mul_req.start = 1'b1;
      mul_req.a     = {{16{tot_sum_q[tix][47]}}, tot_sum_q[tix]};
      mul_req.b     = {32'd0, recip_q};
      mul_req.sh16  = 1'b1;
    end else if (state_q == ST_AC_DNEW) begin
      mul_req.start = 1'b1;
      mul_req.a     = sat_sub64(v_q, nm_q);
      mul_req.b     = dold_q;
    end
  end

  always_comb begin
    div_req          = '0;
    div_req.start    = (state_q == ST_AC_SUB);
    div_req.dividend = sat_sub64(v_q, mean_q);
    div_req.divisor  = n_q;
  end

  // Bin memory writes: the clearing sweep, the score update and the final
  // write of a bin's new statistics.
  always_comb begin
    sum_we     = 1'b0;
    stat_we    = 1'b0;
    sum_wdata  = '0;
    stat_wdata = '0;
    if (state_q == ST_CLEAR) begin
      sum_we  = 1'b1;
      stat_we = clr_all_q;
    end else if (state_q == ST_SC_WR && cmd_q != CMD_ESCAPE) begin
      sum_we    = 1'b1;
      sum_wdata = sum_rdata;
      if (cmd_q == CMD_RC) begin
        sum_wdata.rc_sum = sum_add48(sum_rdata.rc_sum, w_q);
      end else begin
        sum_wdata.ac_sum = sum_add48(sum_rdata.ac_sum, w_q);
      end
    end else if (state_q == ST_AC_MUL && mul_done && !is_total && half_q) begin
      stat_we            = 1'b1;
      stat_wdata         = ent_stat_q;
      stat_wdata.ac_mean = nm_q;
      stat_wdata.ac_m2   = m2_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      bin_scale_q <= 32'd65536;
      recip_q     <= 32'd4294967;
      clr_all_q   <= 1'b1;
      addr_q      <= '0;
      valid_o     <= 1'b0;
      t_idx_q     <= '0;
      half_q      <= 1'b0;
      for (int i = 0; i < NUM_TOTALS; i++) begin
        tot_sum_q[i]  <= '0;
        tot_mean_q[i] <= '0;
        tot_m2_q[i]   <= '0;
      end
    end else begin
      // The result strobe is registered from the output state.
      valid_o <= (state_q == ST_RD_OUT);

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BIN_SCALE) begin
          bin_scale_q <= cfg_wdata_i;
        end else begin
          recip_q <= cfg_wdata_i;
        end
      end

      unique case (state_q)
        ST_CLEAR: begin
          addr_q  <= addr_q + 1'b1;
          state_q <= (addr_q == LAST_BIN) ? ST_IDLE : ST_CLEAR;
        end

        ST_IDLE: begin
          if (accept) begin
            cmd_q <= command_i;
            w_q   <= weight_i;
            n_q   <= (batch_number_i == 16'd0) ? 16'd1 : batch_number_i;
            unique case (command_i)
              CMD_ESCAPE: begin
                t_idx_q <= 3'd0;
                state_q <= ST_SC_WR;
              end
              CMD_RC, CMD_AC: begin
                t_idx_q <= command_i;
                if (position_i[31]) begin
                  addr_q  <= '0;
                  state_q <= ST_SC_RD;
                end else begin
                  state_q <= ST_SC_BIN;
                end
              end
              CMD_ACCUM: begin
                t_idx_q <= 3'd0;
                half_q  <= 1'b0;
                state_q <= ST_AC_LOAD;
              end
              CMD_ZBATCH, CMD_ZALL: begin
                for (int i = 0; i < NUM_TOTALS; i++) begin
                  tot_sum_q[i] <= '0;
                  if (command_i == CMD_ZALL) begin
                    tot_mean_q[i] <= '0;
                    tot_m2_q[i]   <= '0;
                  end
                end
                clr_all_q <= (command_i == CMD_ZALL);
                addr_q    <= '0;
                state_q   <= ST_CLEAR;
              end
              CMD_READ: begin
                t_idx_q <= read_target_i;
                oob_q   <= (32'(read_bin_i) >= 32'(BINS));
                addr_q  <= (32'(read_bin_i) >= 32'(BINS)) ? '0 : BW'(read_bin_i);
                state_q <= ST_RD_RD;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        ST_SC_BIN: begin
          if (mul_done) begin
            addr_q  <= (mul_res >= 64'(BINS)) ? LAST_BIN : mul_res[BW-1:0];
            state_q <= ST_SC_RD;
          end
        end

        ST_SC_RD: state_q <= ST_SC_WR;

        ST_SC_WR: begin
          tot_sum_q[tix] <= sum_add48(tot_sum_q[tix], w_q);
          state_q        <= ST_IDLE;
        end

        ST_RD_RD: state_q <= ST_RD_OUT;

        ST_RD_OUT: begin
          if (is_total) begin
            mean_value_o <= tot_mean_q[tix];
            sum_sq_dev_o <= tot_m2_q[tix];
            batch_sum_o  <= tot_sum_q[tix];
            status_o     <= 1'b0;
          end else if (t_idx_q == TGT_RC_BIN && !oob_q) begin
            mean_value_o <= stat_rdata.rc_mean;
            sum_sq_dev_o <= stat_rdata.rc_m2;
            batch_sum_o  <= sum_rdata.rc_sum;
            status_o     <= 1'b0;
          end else if (t_idx_q == TGT_AC_BIN && !oob_q) begin
            mean_value_o <= stat_rdata.ac_mean;
            sum_sq_dev_o <= stat_rdata.ac_m2;
            batch_sum_o  <= sum_rdata.ac_sum;
            status_o     <= 1'b0;
          end else begin
            // Unknown targets read as zero; a bin target here is out of range.
            mean_value_o <= '0;
            sum_sq_dev_o <= '0;
            batch_sum_o  <= '0;
            status_o     <= (t_idx_q == TGT_RC_BIN || t_idx_q == TGT_AC_BIN);
          end
          state_q <= ST_IDLE;
        end

        ST_AC_LOAD: begin
          // Totals start the scaling multiply here; bins present the address.
          if (is_total) begin
            mean_q  <= tot_mean_q[tix];
            m2_q    <= tot_m2_q[tix];
            state_q <= ST_AC_V;
          end else begin
            state_q <= ST_AC_BRD;
          end
        end

        ST_AC_BRD: begin
          ent_sum_q  <= sum_rdata;
          ent_stat_q <= stat_rdata;
          v_q        <= {sum_rdata.rc_sum, 16'd0};
          mean_q     <= stat_rdata.rc_mean;
          m2_q       <= stat_rdata.rc_m2;
          half_q     <= 1'b0;
          state_q    <= ST_AC_SUB;
        end

        ST_AC_V: begin
          if (mul_done) begin
            v_q     <= mul_res;
            state_q <= ST_AC_SUB;
          end
        end

        ST_AC_SUB: begin
          dold_q  <= sat_sub64(v_q, mean_q);
          state_q <= ST_AC_DIV;
        end

        ST_AC_DIV: begin
          if (div_done) begin
            nm_q    <= sat_add64(mean_q, div_quot);
            state_q <= ST_AC_DNEW;
          end
        end

        ST_AC_DNEW: state_q <= ST_AC_MUL;

        ST_AC_MUL: begin
          if (mul_done) begin
            if (is_total) begin
              tot_mean_q[tix] <= nm_q;
              tot_m2_q[tix]   <= m2_new;
              if (t_idx_q == 3'(NUM_TOTALS - 1)) begin
                addr_q <= '0;
              end
              t_idx_q <= t_idx_q + 3'd1;
              state_q <= ST_AC_LOAD;
            end else if (!half_q) begin
              ent_stat_q.rc_mean <= nm_q;
              ent_stat_q.rc_m2   <= m2_new;
              v_q                <= {ent_sum_q.ac_sum, 16'd0};
              mean_q             <= ent_stat_q.ac_mean;
              m2_q               <= ent_stat_q.ac_m2;
              half_q             <= 1'b1;
              state_q            <= ST_AC_SUB;
            end else begin
              addr_q  <= addr_q + 1'b1;
              state_q <= (addr_q == LAST_BIN) ? ST_IDLE : ST_AC_LOAD;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The result beat is produced only by the read path, which never repeats.
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held for two cycles");

  a_valid_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_RD_OUT))
    else $error("result strobe without a read");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (mean_value_o == 64'sd0 && sum_sq_dev_o == 64'sd0 &&
                              batch_sum_o == 48'sd0))
    else $error("out-of-range read returned data");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done)) else $error("multiplier and divider finished together");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_READ) |=> busy)
    else $error("read taken without going busy");

endmodule

// ----- dv/tb_weighted_histogram_batch_statistics_unit.sv -----
// ============================================================================
// tb_weighted_histogram_batch_statistics_unit: self-checking bench
// Drives score, accumulate, zero and read beats with random gaps, keeps its
// own tally and Welford statistics, and checks every read beat field by field.
// ============================================================================
module tb_weighted_histogram_batch_statistics_unit;
  import whbs_pkg::*;

  // Read targets below the histogram ones, and the unused command code.
  localparam logic [2:0] TGT_LEAK   = 3'd0;
  localparam logic [2:0] TGT_RC_TOT = 3'd1;
  localparam logic [2:0] TGT_AC_TOT = 3'd2;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int         NBINS      = BINS_DEF;
  // An accumulate walks every bin through the divider with no result beat,
  // so the stall limit must cover a whole accumulate.
  localparam int         STALL_LIMIT = 300000;

  typedef struct {
    longint mean;
    longint m2;
    longint sum;
    logic   status;
  } read_beat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               start;
  logic               busy;
  logic [2:0]         command_i;
  logic signed [31:0] weight_i;
  logic signed [31:0] position_i;
  logic [15:0]        batch_number_i;
  logic [2:0]         read_target_i;
  logic [7:0]         read_bin_i;
  logic               valid_o;
  logic signed [63:0] mean_value_o;
  logic signed [63:0] sum_sq_dev_o;
  logic signed [47:0] batch_sum_o;
  logic               status_o;

  weighted_histogram_batch_statistics_unit dut (.*);

  // Mirror of the block state.
  longint unsigned scale_q16;
  longint unsigned recip_q32;
  longint          tally_sum[3];
  longint          tally_mean[3];
  longint          tally_m2[3];
  longint          rc_bin_sum[NBINS];
  longint          ac_bin_sum[NBINS];
  longint          rc_bin_mean[NBINS];
  longint          rc_bin_m2[NBINS];
  longint          ac_bin_mean[NBINS];
  longint          ac_bin_m2[NBINS];

  read_beat_t pending_reads[$];
  int         err_count;
  int         beats_sent;
  int         reads_checked;
  int         accums_sent;
  int         quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) s = (a < 0) ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    longint s;
    s = a - b;
    if ((a < 0) != (b < 0) && (s < 0) != (a < 0)) s = (a < 0) ? S64_MIN : S64_MAX;
    return s;
  endfunction

  // Exact product, floor-shifted right, then clamped into 64 bits.
  function automatic longint prod_shift_sat(longint a, longint b, int sh);
    logic signed [127:0] ea, eb, q;
    ea = a;
    eb = b;
    q  = (ea * eb) >>> sh;
    if (q[127:63] != {65{q[127]}}) return q[127] ? S64_MIN : S64_MAX;
    return q[63:0];
  endfunction

  // Batch sums live in 48 bits and clamp at the edges.
  function automatic longint tally_add(longint s, logic signed [31:0] w);
    longint r;
    r = s + longint'(w);
    if (r > longint'(S48_MAX)) r = S48_MAX;
    if (r < longint'(S48_MIN)) r = S48_MIN;
    return r;
  endfunction

  function automatic int hist_bin(logic signed [31:0] pos);
    longint unsigned b;
    if (pos < 0) return 0;
    b = (longint'(pos) * scale_q16) >> 32;
    return (b >= NBINS) ? NBINS - 1 : int'(b);
  endfunction

  task automatic welford_step(inout longint mean, inout longint m2,
                              input longint v, input longint n);
    longint d_old, nm;
    d_old = sub_sat(v, mean);
    nm    = add_sat(mean, d_old / n);
    m2    = add_sat(m2, prod_shift_sat(sub_sat(v, nm), d_old, 32));
    mean  = nm;
  endtask

  task automatic clear_batch();
    for (int b = 0; b < NBINS; b++) begin
      rc_bin_sum[b] = 0;
      ac_bin_sum[b] = 0;
    end
    for (int t = 0; t < 3; t++) tally_sum[t] = 0;
  endtask

  task automatic clear_all();
    for (int b = 0; b < NBINS; b++) begin
      rc_bin_mean[b] = 0;
      rc_bin_m2[b]   = 0;
      ac_bin_mean[b] = 0;
      ac_bin_m2[b]   = 0;
    end
    for (int t = 0; t < 3; t++) begin
      tally_mean[t] = 0;
      tally_m2[t]   = 0;
    end
    clear_batch();
  endtask

  // Applies one accepted beat to the mirror and queues the read result.
  task automatic tally_predict(logic [2:0] cmd, logic signed [31:0] w,
                               logic signed [31:0] pos, logic [15:0] bn,
                               logic [2:0] tgt, logic [7:0] rbin);
    longint     n, v;
    int         b;
    read_beat_t r;
    n = (bn == 0) ? 1 : longint'(bn);
    case (cmd)
      CMD_ESCAPE: tally_sum[0] = tally_add(tally_sum[0], w);
      CMD_RC: begin
        tally_sum[1] = tally_add(tally_sum[1], w);
        b = hist_bin(pos);
        rc_bin_sum[b] = tally_add(rc_bin_sum[b], w);
      end
      CMD_AC: begin
        tally_sum[2] = tally_add(tally_sum[2], w);
        b = hist_bin(pos);
        ac_bin_sum[b] = tally_add(ac_bin_sum[b], w);
      end
      CMD_ACCUM: begin
        for (int t = 0; t < 3; t++) begin
          v = prod_shift_sat(tally_sum[t], longint'(recip_q32), 16);
          welford_step(tally_mean[t], tally_m2[t], v, n);
        end
        for (int k = 0; k < NBINS; k++) begin
          welford_step(rc_bin_mean[k], rc_bin_m2[k], rc_bin_sum[k] * 65536, n);
          welford_step(ac_bin_mean[k], ac_bin_m2[k], ac_bin_sum[k] * 65536, n);
        end
      end
      CMD_ZBATCH: clear_batch();
      CMD_ZALL:   clear_all();
      CMD_READ: begin
        r = '{0, 0, 0, 1'b0};
        // The bin index is 8 bits wide, so with 256 bins it never runs out
        // of range and status stays clear.
        if (tgt <= TGT_AC_TOT) begin
          r.mean = tally_mean[tgt];
          r.m2   = tally_m2[tgt];
          r.sum  = tally_sum[tgt];
        end else if (tgt == TGT_RC_BIN) begin
          r.mean = rc_bin_mean[rbin];
          r.m2   = rc_bin_m2[rbin];
          r.sum  = rc_bin_sum[rbin];
        end else if (tgt == TGT_AC_BIN) begin
          r.mean = ac_bin_mean[rbin];
          r.m2   = ac_bin_m2[rbin];
          r.sum  = ac_bin_sum[rbin];
        end
        pending_reads.push_back(r);
      end
      default: ;  // the unused code is swallowed without a result
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Sends one command beat after a random gap. Start stays high across
  // back-to-back beats so it never gets two assignments in one step.
  task automatic send_beat(logic [2:0] cmd, logic signed [31:0] w,
                           logic signed [31:0] pos, logic [15:0] bn,
                           logic [2:0] tgt, logic [7:0] rbin);
    int gap;
    bit taken;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;  // runs of back-to-back beats
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    weight_i       <= w;
    position_i     <= pos;
    batch_number_i <= bn;
    read_target_i  <= tgt;
    read_bin_i     <= rbin;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    tally_predict(cmd, w, pos, bn, tgt, rbin);
    beats_sent++;
    if (cmd == CMD_ACCUM) accums_sent++;
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every read is back and the block has gone idle; a score or
  // zero command leaves no result behind, so busy is the only sign of it.
  task automatic wait_idle();
    release_start();
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    do @(negedge clk_i); while (busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_BIN_SCALE) scale_q16 = data;
    else recip_q32 = data;
  endtask

  task automatic set_config(logic [31:0] scale, logic [31:0] recip);
    wait_idle();
    write_reg(CFG_BIN_SCALE, scale);
    write_reg(CFG_RECIP, recip);
  endtask

  task automatic read_everything();
    for (int t = 0; t < 8; t++) send_beat(CMD_READ, 0, 0, 0, t[2:0], 8'd0);
    send_beat(CMD_READ, 0, 0, 0, TGT_RC_BIN, 8'd255);
    send_beat(CMD_READ, 0, 0, 0, TGT_AC_BIN, 8'd255);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extreme weights and positions, every command and read target, a zero
  // batch number and the unused command code.
  task automatic test_directed();
    send_beat(CMD_ESCAPE, 32'sh7FFF_FFFF, 0, 1, 0, 0);
    send_beat(CMD_ESCAPE, 32'sh8000_0000, 0, 1, 0, 0);
    send_beat(CMD_RC, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, 0);   // negative pos
    send_beat(CMD_RC, 32'sh0001_0000, 32'sh7FFF_FFFF, 1, 0, 0);   // clamps high
    send_beat(CMD_AC, 32'sh8000_0000, 32'sh0000_0000, 1, 0, 0);
    send_beat(CMD_AC, 32'sh7FFF_FFFF, 32'sh0005_8000, 1, 0, 0);
    send_beat(CMD_UNUSED, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'hFFFF, 3'd7, 8'hFF);
    read_everything();
    send_beat(CMD_ACCUM, 0, 0, 16'd0, 0, 0);                      // n taken as 1
    send_beat(CMD_ACCUM, 0, 0, 16'hFFFF, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_LEAK, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_RC_BIN, 8'd255);
    send_beat(CMD_ZBATCH, 0, 0, 0, 0, 0);
    read_everything();
    send_beat(CMD_ZALL, 0, 0, 0, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_AC_TOT, 0);
  endtask

  // Saturation: large totals and bins folded in a few times drive the
  // statistics into their clamps, first with the largest registers.
  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 3; k++) begin
      send_beat(CMD_ESCAPE, 32'sh7FFF_FFFF, 0, 1, 0, 0);
      send_beat(CMD_RC, 32'sh7FFF_FFFF, 32'sh0000_0001, 1, 0, 0);
      send_beat(CMD_AC, 32'sh8000_0000, 32'sh0000_0100, 1, 0, 0);
      send_beat(CMD_ACCUM, 0, 0, 16'(k + 1), 0, 0);
    end
    send_beat(CMD_READ, 0, 0, 0, TGT_LEAK, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_RC_BIN, 8'd1);
    send_beat(CMD_READ, 0, 0, 0, TGT_AC_BIN, 8'd255);
    // Zero registers: every collision in bin 0 and the totals fold in as 0.
    set_config(32'd0, 32'd0);
    send_beat(CMD_RC, 32'sh0003_0000, 32'sh7FFF_0000, 1, 0, 0);
    send_beat(CMD_ACCUM, 0, 0, 16'd4, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_RC_TOT, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_RC_BIN, 8'd0);
    set_config(32'd1, 32'd1);
    send_beat(CMD_AC, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, 0);
    send_beat(CMD_READ, 0, 0, 0, TGT_AC_BIN, 8'd0);
    send_beat(CMD_ZALL, 0, 0, 0, 0, 0);
  endtask

  // Random beats: mostly scores aimed at the occupied bins and reads, with
  // a few accumulates (each walks all bins) and zero commands.
  task automatic test_random(int count);
    logic [2:0]         cmd, tgt;
    logic signed [31:0] w, pos;
    logic [15:0]        bn;
    int                 pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 999);
      if (pick < 150)      cmd = CMD_ESCAPE;
      else if (pick < 380) cmd = CMD_RC;
      else if (pick < 600) cmd = CMD_AC;
      else if (pick < 614) cmd = CMD_ACCUM;
      else if (pick < 624) cmd = CMD_ZBATCH;
      else if (pick < 629) cmd = CMD_ZALL;
      else if (pick < 639) cmd = CMD_UNUSED;
      else                 cmd = CMD_READ;
      w   = ($urandom_range(0, 2) == 0) ? $urandom() : $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
      pos = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000);
      bn  = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20));
      tgt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_beat(cmd, w, pos, bn, tgt, 8'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(negedge clk_i) begin
    read_beat_t e;
    if (rst_ni && valid_o) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result beat", mean_value_o, 0);
      end else begin
        e = pending_reads.pop_front();
        reads_checked++;
        if (mean_value_o !== e.mean) report_mismatch("mean_value", mean_value_o, e.mean);
        if (sum_sq_dev_o !== e.m2) report_mismatch("sum_sq_dev", sum_sq_dev_o, e.m2);
        if (batch_sum_o !== e.sum[47:0]) report_mismatch("batch_sum", batch_sum_o, e.sum);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
      end
    end
  end

  // Watchdog: any accepted command or result beat resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_weighted_histogram_batch_statistics_unit: done, errors");
        $finish;
      end
    end
  end

  initial begin
    err_count = 0;
    beats_sent = 0;
    reads_checked = 0;
    accums_sent = 0;
    quiet_cycles = 0;
    scale_q16 = 65536;
    recip_q32 = 4294967;
    clear_all();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BIN_SCALE;
    cfg_wdata_i = '0;
    start = 1'b0;
    command_i = CMD_ESCAPE;
    weight_i = '0;
    position_i = '0;
    batch_number_i = '0;
    read_target_i = '0;
    read_bin_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_register_extremes();
    set_config(32'd65536, 32'd4294967);
    test_random(250);
    set_config($urandom_range(1, 32'h0004_0000), $urandom());
    test_random(250);
    set_config(32'h0000_8000, 32'hFFFF_FFFF);
    test_random(250);

    wait_idle();
    $display("Sent %0d command beats including %0d accumulates; checked %0d reads.",
             beats_sent, accums_sent, reads_checked);
    if (err_count == 0) begin
      $display("tb_weighted_histogram_batch_statistics_unit: done, clean");
    end else begin
      $display("tb_weighted_histogram_batch_statistics_unit: done, errors");
    end
    $finish;
  end

endmodule
